// ===== rtl/core/rcfd_pkg.sv =====
// Package for the RC receiver frame decoder.
// Holds frame geometry, command and register codes, reset values and shared types.
// No dependencies.
package rcfd_pkg;

    localparam int NUM_BYTES = 18;
    localparam int NUM_CH    = 5;
    localparam int NUM_LIM   = 4;   // channels covered by the range check

    localparam logic [4:0] FRAME_LEN = 5'd18;
    localparam logic [4:0] COUNT_MAX = 5'd31;

    localparam logic [10:0] OFFSET_RST    = 11'd1024;
    localparam logic [10:0] THRESHOLD_RST = 11'd256;
    localparam logic [1:0]  HOLD_MAX_RST  = 2'd2;
    localparam logic [10:0] LIMIT_RST     = 11'd700;

    localparam logic [3:0] SW_ERROR = 4'hA;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_IDLE = 1'b1
    } rcfd_cmd_t;

    typedef enum logic [1:0] {
        REG_OFFSET    = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_HOLD_MAX  = 2'd2,
        REG_LIMIT     = 2'd3
    } rcfd_reg_t;

    typedef logic signed [11:0] chan_t;

    typedef struct packed {
        logic [10:0] offset;
        logic [10:0] threshold;
        logic [1:0]  hold_max;
        logic [10:0] limit;
    } rcfd_cfg_t;

    typedef struct packed {
        logic [15:0]              key_bits;
        logic [15:0]              mouse_buttons;
        logic [15:0]              mouse_z;
        logic [15:0]              mouse_y;
        logic [15:0]              mouse_x;
        logic [3:0]               switches;
        logic [NUM_CH-1:0][11:0]  chan;      // chan[0] in the lowest bits
        logic                     data_error;
    } rcfd_result_t;

endpackage

// ===== rtl/core/rc_receiver_frame_decoder_unit.sv =====
// RC receiver frame decoder, top level: input word register, 18-byte frame store,
// spike filter state and result register. Uses rcfd_pkg and rcfd_decode.
// The idle word is first registered in the input word register, then decoded into the result register.
// Throughput: one input word per cycle; the input stalls only while a decoded result
// waits for a free output register.
// Reset (aresetn, synchronous, active low): byte count, filter state, registers to defaults.
module rc_receiver_frame_decoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic         s_tuser,    // [0] cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,    // chan0..chan4 (12 each), switches, mouse_x, mouse_y,
                                     // mouse_z, mouse_buttons, key_bits
    output logic         m_tuser,    // [0] data_error
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [10:0]  cfg_wdata
);
    import rcfd_pkg::*;

    rcfd_cfg_t                cfg_reg;
    logic                     in_valid_reg;
    rcfd_cmd_t                in_cmd_reg;
    logic [7:0]               in_byte_reg;
    logic [4:0]               count_reg;
    logic [4:0]               count_next;
    logic [NUM_BYTES-1:0][7:0] frame_reg;
    logic [NUM_CH-1:0][11:0]  held_reg;
    logic [NUM_CH-1:0][1:0]   suspect_reg;
    logic [NUM_CH-1:0][11:0]  held_next;
    logic [NUM_CH-1:0][1:0]   suspect_next;
    rcfd_result_t             dec_result;
    rcfd_result_t             out_reg;
    logic                     out_valid_reg;
    logic                     is_decode;
    logic                     out_free;
    logic                     advance;

    rcfd_decode u_decode (
        .frame        (frame_reg),
        .cfg          (cfg_reg),
        .held         (held_reg),
        .suspect      (suspect_reg),
        .held_next    (held_next),
        .suspect_next (suspect_next),
        .result       (dec_result)
    );

    assign is_decode = in_valid_reg && (in_cmd_reg == CMD_IDLE) && (count_reg == FRAME_LEN);
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!is_decode || out_free);
    assign s_tready  = !in_valid_reg || advance;

    always_comb begin
        count_next = count_reg;
        if (in_cmd_reg == CMD_IDLE) begin
            count_next = 5'd0;
        end else if (count_reg < COUNT_MAX) begin
            count_next = count_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset    <= OFFSET_RST;
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.hold_max  <= HOLD_MAX_RST;
            cfg_reg.limit     <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (rcfd_reg_t'(cfg_addr))
                REG_OFFSET:    cfg_reg.offset    <= cfg_wdata;
                REG_THRESHOLD: cfg_reg.threshold <= cfg_wdata;
                REG_HOLD_MAX:  cfg_reg.hold_max  <= cfg_wdata[1:0];
                REG_LIMIT:     cfg_reg.limit     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= rcfd_cmd_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 5'd0;
            held_reg    <= '0;
            suspect_reg <= '0;
        end else if (advance) begin
            count_reg <= count_next;
            if (is_decode) begin
                held_reg    <= held_next;
                suspect_reg <= suspect_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (in_cmd_reg == CMD_BYTE) && (count_reg < FRAME_LEN)) begin
            frame_reg[count_reg] <= in_byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_decode) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_decode) begin
            out_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.key_bits, out_reg.mouse_buttons, out_reg.mouse_z,
                       out_reg.mouse_y, out_reg.mouse_x, out_reg.switches, out_reg.chan};
    assign m_tuser  = out_reg.data_error;

endmodule

// ===== rtl/core/rcfd_decode.sv =====
// Frame decode for the RC receiver frame decoder: channel unpack, spike filter,
// range/switch check and output mux. Combinational; uses rcfd_pkg.
module rcfd_decode (
    input  logic [rcfd_pkg::NUM_BYTES-1:0][7:0]  frame,
    input  rcfd_pkg::rcfd_cfg_t                   cfg,
    input  logic [rcfd_pkg::NUM_CH-1:0][11:0]     held,
    input  logic [rcfd_pkg::NUM_CH-1:0][1:0]      suspect,
    output logic [rcfd_pkg::NUM_CH-1:0][11:0]     held_next,
    output logic [rcfd_pkg::NUM_CH-1:0][1:0]      suspect_next,
    output rcfd_pkg::rcfd_result_t                result
);
    import rcfd_pkg::*;

    logic [NUM_CH-1:0][10:0] raw;
    logic [NUM_CH-1:0][11:0] filt;
    logic [3:0]              sw;
    logic [NUM_LIM-1:0]      over;
    logic                    err;

    assign raw[0] = {frame[1][2:0], frame[0]};
    assign raw[1] = {frame[2][5:0], frame[1][7:3]};
    assign raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
    assign raw[3] = {frame[5][3:0], frame[4][7:1]};
    assign raw[4] = {frame[17][2:0], frame[16]};
    assign sw     = frame[5][7:4];

    always_comb begin
        logic [11:0] v;
        logic [12:0] d;
        logic [12:0] dmag;
        logic [11:0] hmag;
        for (int i = 0; i < NUM_CH; i++) begin
            v    = {1'b0, raw[i]} - {1'b0, cfg.offset};
            d    = {v[11], v} - {held[i][11], held[i]};
            dmag = d[12] ? 13'(-d) : d;
            if (dmag >= {2'b00, cfg.threshold} && suspect[i] < cfg.hold_max) begin
                filt[i]         = held[i];
                suspect_next[i] = suspect[i] + 2'd1;
            end else begin
                filt[i]         = v;
                suspect_next[i] = 2'd0;
            end
        end
        for (int i = 0; i < NUM_LIM; i++) begin
            hmag    = filt[i][11] ? 12'(-filt[i]) : filt[i];
            over[i] = hmag > {1'b0, cfg.limit};
        end
    end

    assign err = (|over) || (sw[1:0] == 2'b00) || (sw[3:2] == 2'b00);

    always_comb begin
        if (err) begin
            held_next            = '0;
            result               = '0;
            result.switches      = SW_ERROR;
            result.data_error    = 1'b1;
        end else begin
            held_next            = filt;
            result.chan          = filt;
            result.switches      = sw;
            result.mouse_x       = {frame[7], frame[6]};
            result.mouse_y       = {frame[9], frame[8]};
            result.mouse_z       = {frame[11], frame[10]};
            result.mouse_buttons = {frame[13], frame[12]};
            result.key_bits      = {frame[15], frame[14]};
            result.data_error    = 1'b0;
        end
    end

endmodule

// ===== tb/sv/tb_rc_receiver_frame_decoder_unit.sv =====
// Self-checking testbench for rc_receiver_frame_decoder_unit: streams receiver words,
// predicts each decoded frame and compares every result word field by field.
// Depends on rcfd_pkg and the rc_receiver_frame_decoder_unit RTL.
module tb_rc_receiver_frame_decoder_unit;
    import rcfd_pkg::*;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [143:0] m_tdata;
    logic         m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [10:0]  cfg_wdata = '0;

    rc_receiver_frame_decoder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // decoder shadow state
    rcfd_cfg_t    cfg = '{offset: OFFSET_RST, threshold: THRESHOLD_RST,
                          hold_max: HOLD_MAX_RST, limit: LIMIT_RST};
    logic [7:0]   frame_buf [NUM_BYTES];
    int           n_bytes = 0;
    int           held [NUM_CH]    = '{default: 0};
    int           suspect [NUM_CH] = '{default: 0};
    rcfd_result_t expected_frames [$];

    int n_mismatch = 0;
    int n_sent     = 0;
    bit tx_random  = 1'b1;
    bit rx_random  = 1'b1;
    int rx_hold    = 0;
    int rx_stall   = 0;
    int tgt [NUM_CH] = '{default: 0};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #1600000;
        $display("rc_receiver_frame_decoder_unit regression: fail");
        $finish;
    end

    function automatic int magnitude(int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic void track_word(rcfd_cmd_t cmd, logic [7:0] data);
        logic [10:0]  raw [NUM_CH];
        logic [3:0]   sw;
        rcfd_result_t res;
        int           v;
        bit           bad;
        if (cmd == CMD_BYTE) begin
            if (n_bytes < NUM_BYTES) frame_buf[n_bytes] = data;
            if (n_bytes < COUNT_MAX) n_bytes++;
            return;
        end
        if (n_bytes != FRAME_LEN) begin
            n_bytes = 0;
            return;
        end
        n_bytes = 0;
        raw[0] = {frame_buf[1][2:0], frame_buf[0]};
        raw[1] = {frame_buf[2][5:0], frame_buf[1][7:3]};
        raw[2] = {frame_buf[4][0], frame_buf[3], frame_buf[2][7:6]};
        raw[3] = {frame_buf[5][3:0], frame_buf[4][7:1]};
        raw[4] = {frame_buf[17][2:0], frame_buf[16]};
        sw = frame_buf[5][7:4];
        for (int i = 0; i < NUM_CH; i++) begin
            v = int'(raw[i]) - int'(cfg.offset);
            if (magnitude(v - held[i]) >= int'(cfg.threshold) &&
                suspect[i] < int'(cfg.hold_max)) begin
                suspect[i]++;
            end else begin
                held[i]    = v;
                suspect[i] = 0;
            end
        end
        bad = (sw[1:0] == 2'd0) || (sw[3:2] == 2'd0);
        for (int i = 0; i < NUM_LIM; i++)
            if (magnitude(held[i]) > int'(cfg.limit)) bad = 1'b1;
        res = '0;
        if (bad) begin
            foreach (held[i]) held[i] = 0;
            res.switches   = SW_ERROR;
            res.data_error = 1'b1;
        end else begin
            for (int i = 0; i < NUM_CH; i++) res.chan[i] = 12'(held[i]);
            res.switches      = sw;
            res.mouse_x       = {frame_buf[7], frame_buf[6]};
            res.mouse_y       = {frame_buf[9], frame_buf[8]};
            res.mouse_z       = {frame_buf[11], frame_buf[10]};
            res.mouse_buttons = {frame_buf[13], frame_buf[12]};
            res.key_bits      = {frame_buf[15], frame_buf[14]};
        end
        expected_frames.push_back(res);
    endfunction

    task automatic report_mismatch(string msg);
        n_mismatch++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin : check_results
        rcfd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("result word with no frame pending");
            end else begin
                want = expected_frames.pop_front();
                for (int i = 0; i < NUM_CH; i++)
                    compare_field($sformatf("chan%0d", i), 16'(m_tdata[12*i +: 12]),
                                  16'(want.chan[i]));
                compare_field("switches", 16'(m_tdata[63:60]), 16'(want.switches));
                compare_field("mouse_x", m_tdata[79:64], want.mouse_x);
                compare_field("mouse_y", m_tdata[95:80], want.mouse_y);
                compare_field("mouse_z", m_tdata[111:96], want.mouse_z);
                compare_field("mouse_buttons", m_tdata[127:112], want.mouse_buttons);
                compare_field("key_bits", m_tdata[143:128], want.key_bits);
                compare_field("data_error", 16'(m_tuser), 16'(want.data_error));
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // result side: long hold-off first, then random stalls or always ready
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (!rx_random) begin
                m_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25) rx_stall = pick_gap();
            end
        end
    end

    task automatic send_word(rcfd_cmd_t cmd, logic [7:0] data);
        int gap;
        gap = tx_random ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        track_word(cmd, data);
        n_sent++;
    endtask

    task automatic send_frame(logic [NUM_CH-1:0][10:0] raw, logic [3:0] sw);
        logic [7:0] b [NUM_BYTES];
        foreach (b[i]) b[i] = 8'($urandom);
        b[0]        = raw[0][7:0];
        b[1]        = {raw[1][4:0], raw[0][10:8]};
        b[2]        = {raw[2][1:0], raw[1][10:5]};
        b[3]        = raw[2][9:2];
        b[4]        = {raw[3][6:0], raw[2][10]};
        b[5]        = {sw, raw[3][10:7]};
        b[16]       = raw[4][7:0];
        b[17][2:0]  = raw[4][10:8];
        foreach (b[i]) send_word(CMD_BYTE, b[i]);
        send_word(CMD_IDLE, 8'($urandom));
    endtask

    function automatic logic [10:0] raw_of(int v);
        return 11'(int'(cfg.offset) + v);
    endfunction

    task automatic send_chans(int d0, int d1, int d2, int d3, int d4, logic [3:0] sw);
        logic [NUM_CH-1:0][10:0] raw;
        raw[0] = raw_of(d0);
        raw[1] = raw_of(d1);
        raw[2] = raw_of(d2);
        raw[3] = raw_of(d3);
        raw[4] = raw_of(d4);
        send_frame(raw, sw);
    endtask

    task automatic send_burst(int len);
        repeat (len) send_word(CMD_BYTE, 8'($urandom));
        send_word(CMD_IDLE, 8'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(rcfd_reg_t idx, logic [10:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_OFFSET:    cfg.offset    = val;
            REG_THRESHOLD: cfg.threshold = val;
            REG_HOLD_MAX:  cfg.hold_max  = val[1:0];
            REG_LIMIT:     cfg.limit     = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(int off, int thr, int hold, int lim);
        wait_idle();
        write_reg(REG_OFFSET, 11'(off));
        write_reg(REG_THRESHOLD, 11'(thr));
        write_reg(REG_HOLD_MAX, 11'(hold));
        write_reg(REG_LIMIT, 11'(lim));
    endtask

    function automatic int pick_level(int prev);
        int lo, hi, v, r;
        lo = -int'(cfg.limit);
        if (lo < -int'(cfg.offset)) lo = -int'(cfg.offset);
        hi = int'(cfg.limit);
        if (hi > 2047 - int'(cfg.offset)) hi = 2047 - int'(cfg.offset);
        r = $urandom_range(0, 9);
        if (r >= 8) return int'($urandom_range(0, 2047)) - int'(cfg.offset);
        if (r < 4) v = prev + int'($urandom_range(0, 64)) - 32;
        else       v = lo + int'($urandom_range(0, hi - lo));
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic logic [3:0] good_switches();
        return {2'($urandom_range(1, 3)), 2'($urandom_range(1, 3))};
    endfunction

    // defaults after reset, then bursts of wrong length incl. counter saturation
    task automatic test_bursts();
        send_chans(0, 0, 0, 0, 0, 4'b1101);
        send_burst(0);
        send_burst(17);
        send_burst(19);
        send_burst(50);
        send_chans(100, -100, 5, -5, 0, 4'b1110);
    endtask

    task automatic test_spike_filter();
        send_chans(0, 0, 0, 0, 0, 4'b0101);
        repeat (3) send_chans(256, 255, -300, 0, 600, 4'b0101);
        send_chans(0, 0, 0, 0, 0, 4'b1111);
    endtask

    // no hold: range and switch checks act on the first frame
    task automatic test_error_check();
        set_config(1024, 256, 0, 700);
        send_chans(701, 0, 0, 0, 0, 4'b0101);
        send_chans(0, 0, 0, -700, 1023, 4'b1010);
        send_chans(0, 0, -701, 0, 0, 4'b1111);
        send_chans(700, 0, 0, 0, -1024, 4'b1100);
        send_chans(0, 0, 0, 0, 0, 4'b0011);
        send_chans(0, 700, 0, 0, 0, 4'b1111);
    endtask

    task automatic test_config_extremes();
        set_config(0, 0, 3, 2047);
        repeat (5) send_chans($urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), good_switches());
        set_config(2047, 2047, 0, 0);
        send_chans(0, 0, 0, 0, 0, 4'b1111);
        send_chans(0, 0, 0, 0, -2047, 4'b0101);
        send_chans(-1, 0, 0, 0, 0, 4'b1111);
        send_chans(-2047, -2047, -2047, -2047, -2047, 4'b1111);
        set_config(OFFSET_RST, THRESHOLD_RST, HOLD_MAX_RST, LIMIT_RST);
        foreach (tgt[i]) tgt[i] = 0;
    endtask

    task automatic test_random_traffic(int n_items);
        int start, r, len;
        logic [NUM_CH-1:0][10:0] raw;
        start = n_sent;
        while (n_sent - start < n_items) begin
            set_config($urandom_range(0, 1) ? $urandom_range(900, 1150) : $urandom_range(0, 2047),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(16, 400),
                       $urandom_range(0, 3),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(400, 2047));
            tx_random = ($urandom_range(0, 3) != 0);
            rx_random = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(6, 10)) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    foreach (tgt[i]) tgt[i] = pick_level(tgt[i]);
                    send_chans(tgt[0], tgt[1], tgt[2], tgt[3], tgt[4],
                               $urandom_range(0, 9) == 0 ? 4'($urandom) : good_switches());
                end else if (r < 80) begin
                    len = $urandom_range(0, 40);
                    send_burst(len == 18 ? 19 : len);
                end else if (r < 90) begin
                    foreach (raw[i]) raw[i] = 11'($urandom);
                    send_frame(raw, 4'($urandom));
                end else begin
                    repeat ($urandom_range(1, 3)) send_word(CMD_IDLE, 8'($urandom));
                end
            end
        end
        tx_random = 1'b1;
        rx_random = 1'b1;
    endtask

    // receiver holds off while frames stream back to back; input must stall
    task automatic test_backpressure();
        set_config(1024, 300, 1, 900);
        tx_random = 1'b0;
        rx_hold   = 300;
        repeat (6) begin
            foreach (tgt[i]) tgt[i] = pick_level(tgt[i]);
            send_chans(tgt[0], tgt[1], tgt[2], tgt[3], tgt[4], good_switches());
        end
        tx_random = 1'b1;
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_bursts();
        test_spike_filter();
        test_error_check();
        test_config_extremes();
        test_random_traffic(200);
        test_backpressure();
        wait_idle();

        if (n_mismatch == 0) begin
            $display("rc_receiver_frame_decoder_unit regression: pass");
        end else begin
            $display("rc_receiver_frame_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rcfd_pkg.sv
rtl/core/rcfd_decode.sv
rtl/core/rc_receiver_frame_decoder_unit.sv
tb/sv/tb_rc_receiver_frame_decoder_unit.sv
